FILE: design/heap_sort_engine_assert.svh
// Assertion macros used by the heap sort engine sequencer (hse_ctrl).
// Depends on nothing; modules that use it provide i_clk and i_rst_n.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge, ignored while reset is asserted.
`define HSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define HSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HSE_ASSERT(lbl, prop, msg)
`define HSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/hse_pkg.sv
// Types and constants for the heap sort engine.
// Used by hse_ctrl and heap_sort_engine; depends on nothing.
package hse_pkg;

    // Store geometry.
    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = IDX_W + 2;

    // Payload widths.
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 16;
    localparam int TDATA_W = VALUE_W + 2 * TOTAL_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Sequencer states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_BRD,
        S_BHOLD,
        S_SRD,
        S_SCMP,
        S_XRD,
        S_XSW,
        S_ORD,
        S_OLD
    } t_state;

    // Access request from the sequencer to the heap memory.
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr_a;
        logic [IDX_W-1:0]   raddr_b;
    } t_ram_req;

    // One sorted result handed to the output register.
    typedef struct packed {
        logic               load;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [TOTAL_W-1:0] swaps;
        logic [TOTAL_W-1:0] compares;
    } t_out_item;

endpackage

FILE: design/hse_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// Depends on nothing.
module hse_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: design/hse_ctrl.sv
// Load, heap build, extraction and readout sequencer of the heap sort engine.
// Depends on hse_pkg and heap_sort_engine_assert.svh; drives hse_ram.
`include "heap_sort_engine_assert.svh"

module hse_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [hse_pkg::VALUE_W-1:0]     i_in_value,
    input  logic                            i_in_last,
    input  logic                            i_out_free,
    output hse_pkg::t_out_item              o_out_item,
    output hse_pkg::t_ram_req               o_ram_req,
    input  logic [hse_pkg::VALUE_W-1:0]     i_rd_a,
    input  logic [hse_pkg::VALUE_W-1:0]     i_rd_b
);

    hse_pkg::t_state r_state, n_state;

    logic [hse_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [hse_pkg::CNT_W-1:0]   r_n, n_n;
    logic [hse_pkg::CNT_W-1:0]   r_i, n_i;
    logic [hse_pkg::CNT_W-1:0]   r_size, n_size;
    logic [hse_pkg::IDX_W-1:0]   r_node, n_node;
    logic [hse_pkg::VALUE_W-1:0] r_held, n_held;
    logic                        r_build, n_build;
    logic [hse_pkg::TOTAL_W-1:0] r_swap, n_swap;
    logic [hse_pkg::TOTAL_W-1:0] r_cmp, n_cmp;

    logic                          in_xfer;
    logic [hse_pkg::CNT_W-1:0]     load_n;
    logic [hse_pkg::CNT_W-1:0]     load_half;
    logic [hse_pkg::CHILD_W-1:0]   lc, rc, size_ext;
    logic                          lc_ok, rc_ok;
    logic                          take_l, take_r;
    logic [hse_pkg::VALUE_W-1:0]   top_val;
    logic [hse_pkg::IDX_W-1:0]     top_idx;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign load_n    = r_cnt + hse_pkg::CNT_W'(1);
    assign load_half = load_n >> 1;

    // Children of the node under sift-down and the larger of node and children.
    assign lc       = {1'b0, r_node, 1'b0} + hse_pkg::CHILD_W'(1);
    assign rc       = {1'b0, r_node, 1'b0} + hse_pkg::CHILD_W'(2);
    assign size_ext = hse_pkg::CHILD_W'(r_size);
    assign lc_ok    = lc < size_ext;
    assign rc_ok    = rc < size_ext;
    assign take_l   = lc_ok && ($signed(i_rd_a) > $signed(r_held));

    always_comb begin
        top_val = take_l ? i_rd_a : r_held;
        top_idx = take_l ? lc[hse_pkg::IDX_W-1:0] : r_node;
        take_r  = rc_ok && ($signed(i_rd_b) > $signed(top_val));
        if (take_r) begin
            top_val = i_rd_b;
            top_idx = rc[hse_pkg::IDX_W-1:0];
        end
    end

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hse_pkg::S_LOAD;
            r_cnt   <= '0;
            r_swap  <= '0;
            r_cmp   <= '0;
            r_build <= 1'b0;
            r_n     <= '0;
            r_i     <= '0;
            r_size  <= '0;
            r_node  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_swap  <= n_swap;
            r_cmp   <= n_cmp;
            r_build <= n_build;
            r_n     <= n_n;
            r_i     <= n_i;
            r_size  <= n_size;
            r_node  <= n_node;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    // Next state, memory requests and result handoff.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_i       = r_i;
        n_size    = r_size;
        n_node    = r_node;
        n_held    = r_held;
        n_build   = r_build;
        n_swap    = r_swap;
        n_cmp     = r_cmp;
        o_in_ready = 1'b0;
        o_ram_req  = '0;
        o_out_item = '0;
        o_out_item.value    = i_rd_a;
        o_out_item.last     = (r_i == r_n - hse_pkg::CNT_W'(1));
        o_out_item.swaps    = r_swap;
        o_out_item.compares = r_cmp;

        unique case (r_state)
            hse_pkg::S_LOAD: begin
                o_in_ready       = 1'b1;
                o_ram_req.we     = in_xfer;
                o_ram_req.waddr  = r_cnt[hse_pkg::IDX_W-1:0];
                o_ram_req.wdata  = i_in_value;
                if (in_xfer) begin
                    if (i_in_last || r_cnt == hse_pkg::CNT_W'(hse_pkg::DEPTH - 1)) begin
                        n_n    = load_n;
                        n_cnt  = '0;
                        n_swap = '0;
                        n_cmp  = '0;
                        if (load_half != '0) begin
                            n_i     = load_half - hse_pkg::CNT_W'(1);
                            n_build = 1'b1;
                            n_state = hse_pkg::S_BRD;
                        end else begin
                            n_i     = '0;
                            n_build = 1'b0;
                            n_state = hse_pkg::S_XRD;
                        end
                    end else begin
                        n_cnt = load_n;
                    end
                end
            end
            hse_pkg::S_BRD: begin
                o_ram_req.re      = 1'b1;
                o_ram_req.raddr_a = r_i[hse_pkg::IDX_W-1:0];
                n_state = hse_pkg::S_BHOLD;
            end
            hse_pkg::S_BHOLD: begin
                n_held  = i_rd_a;
                n_node  = r_i[hse_pkg::IDX_W-1:0];
                n_size  = r_n;
                n_state = hse_pkg::S_SRD;
            end
            hse_pkg::S_SRD: begin
                o_ram_req.re      = 1'b1;
                o_ram_req.raddr_a = lc[hse_pkg::IDX_W-1:0];
                o_ram_req.raddr_b = rc[hse_pkg::IDX_W-1:0];
                n_state = hse_pkg::S_SCMP;
            end
            hse_pkg::S_SCMP: begin
                // Two comparisons per visit, saturating.
                n_cmp = (r_cmp >= hse_pkg::TOTAL_MAX - hse_pkg::TOTAL_W'(1)) ?
                        hse_pkg::TOTAL_MAX : r_cmp + hse_pkg::TOTAL_W'(2);
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_node;
                if (take_l || take_r) begin
                    // Child moves up; the held value keeps sinking.
                    o_ram_req.wdata = top_val;
                    if (r_swap != hse_pkg::TOTAL_MAX) begin
                        n_swap = r_swap + hse_pkg::TOTAL_W'(1);
                    end
                    n_node  = top_idx;
                    n_state = hse_pkg::S_SRD;
                end else begin
                    o_ram_req.wdata = r_held;
                    if (r_build) begin
                        if (r_i == '0) begin
                            n_build = 1'b0;
                            n_i     = r_n - hse_pkg::CNT_W'(1);
                            n_state = hse_pkg::S_XRD;
                        end else begin
                            n_i     = r_i - hse_pkg::CNT_W'(1);
                            n_state = hse_pkg::S_BRD;
                        end
                    end else begin
                        if (r_i == '0) begin
                            n_state = hse_pkg::S_ORD;
                        end else begin
                            n_i     = r_i - hse_pkg::CNT_W'(1);
                            n_state = hse_pkg::S_XRD;
                        end
                    end
                end
            end
            hse_pkg::S_XRD: begin
                o_ram_req.re      = 1'b1;
                o_ram_req.raddr_a = '0;
                o_ram_req.raddr_b = r_i[hse_pkg::IDX_W-1:0];
                n_state = hse_pkg::S_XSW;
            end
            hse_pkg::S_XSW: begin
                // Old root goes to the tail; the tail value sifts from the root.
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_i[hse_pkg::IDX_W-1:0];
                o_ram_req.wdata = i_rd_a;
                n_held  = i_rd_b;
                n_node  = '0;
                n_size  = r_i;
                n_state = hse_pkg::S_SRD;
            end
            hse_pkg::S_ORD: begin
                o_ram_req.re      = 1'b1;
                o_ram_req.raddr_a = r_i[hse_pkg::IDX_W-1:0];
                n_state = hse_pkg::S_OLD;
            end
            hse_pkg::S_OLD: begin
                if (i_out_free) begin
                    o_out_item.load = 1'b1;
                    if (o_out_item.last) begin
                        n_i     = '0;
                        n_state = hse_pkg::S_LOAD;
                    end else begin
                        n_i     = r_i + hse_pkg::CNT_W'(1);
                        n_state = hse_pkg::S_ORD;
                    end
                end
            end
            default: begin
                n_state = hse_pkg::S_LOAD;
            end
        endcase
    end

    // Sanity checks on the sequencer.
    `HSE_ASSERT(a_node_in_set, (r_state == hse_pkg::S_SCMP) |-> (hse_pkg::CNT_W'(r_node) < r_n), "sift-down node outside the loaded set")
    `HSE_ASSERT(a_cmp_monotonic, (r_state == hse_pkg::S_SCMP) |=> (r_cmp >= $past(r_cmp)), "compare total went backwards during a sort")
    `HSE_ASSERT(a_no_overlap, !(in_xfer && o_out_item.load), "input transfer during readout")
    `HSE_ASSERT(a_out_in_range, o_out_item.load |-> (r_i < r_n), "readout index past the set size")
    `HSE_ASSERT(a_load_cnt, (r_state == hse_pkg::S_LOAD) |-> (r_cnt < hse_pkg::CNT_W'(hse_pkg::DEPTH)), "load count reached the store depth")

endmodule

FILE: design/heap_sort_engine.sv
// Heap sort engine: streams a set of signed values in and back out in ascending order.
//
// Input channel (s_axis): one 32-bit signed value per transfer in tdata; tlast closes
// the set. The transfer that fills the store to 64 entries also closes the set,
// whatever tlast says. Loading takes one cycle per value.
// After the set closes, the values are heap-sorted in place in a 64-entry RAM with
// one write and two read ports: a max-heap build, then repeated root extraction.
// Each sift-down level reads both children, then compares and writes back, and each
// sift-down starts with a setup read of the value to sink (S_BRD/S_BHOLD or S_XRD/S_XSW).
// Output channel (m_axis): one transfer per value, smallest first, read from the RAM
// then put in the output register. tlast marks the largest value; tdata also carries
// the set's sift-down swap total and compare total, both saturating at 65535.
// New input is taken only after the last result has been placed in the output
// register. If the receiver stalls, the readout holds until that register is free.
// Reset (synchronous, active low) empties the output register and returns the
// block to loading with an empty set; RAM contents are not cleared.
module heap_sort_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [hse_pkg::VALUE_W-1:0]     i_s_axis_tdata,  // [31:0] value
    input  logic                            i_s_axis_tlast,
    // Output stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] sorted_value, [47:32] swap_count, [63:48] compare_count
    output logic [hse_pkg::TDATA_W-1:0]     o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    hse_pkg::t_ram_req   ram_req;
    hse_pkg::t_out_item  out_item;
    logic [hse_pkg::VALUE_W-1:0] rd_a, rd_b;
    logic                        out_free;
    logic                        r_out_valid;
    logic [hse_pkg::TDATA_W-1:0] r_out_data;
    logic                        r_out_last;

    hse_ram #(
        .DATA_W (hse_pkg::VALUE_W),
        .ADDR_W (hse_pkg::IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_waddr   (ram_req.waddr),
        .i_wdata   (ram_req.wdata),
        .i_re      (ram_req.re),
        .i_raddr_a (ram_req.raddr_a),
        .i_raddr_b (ram_req.raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    hse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_in_value (i_s_axis_tdata),
        .i_in_last  (i_s_axis_tlast),
        .i_out_free (out_free),
        .o_out_item (out_item),
        .o_ram_req  (ram_req),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b)
    );

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_item.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; loaded only while the register is free.
    always_ff @(posedge i_clk) begin
        if (out_item.load) begin
            r_out_data <= {out_item.compares, out_item.swaps, out_item.value};
            r_out_last <= out_item.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule
